>>> rtl/btpc_pkg.sv
// Shared types and constants for the barometric compensation block.
package btpc_pkg;

  // Register indexes on the configuration port (paddr[4:3]).
  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  localparam int FRONT_STAGES = 11;
  localparam int DIV_STAGES   = 64;
  localparam int FIFO_DEPTH   = 4;
  // Accepting edge to the edge that samples the result strobe.
  localparam int PIPE_LATENCY = 82;

  localparam logic [20:0]        P_BASE     = 21'd1048576;
  localparam logic signed [31:0] T_ROUND    = 32'sd128;
  localparam logic signed [31:0] T_FINE_OFS = 32'sd128000;
  localparam logic signed [54:0] P_BIAS     = 55'sh800000000000;
  localparam logic signed [12:0] NUM_SCALE  = 13'sd3125;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // One classified item waiting for the divider.
  typedef struct packed {
    logic [31:0] tfine;
    logic [26:0] tcent;
    logic [63:0] num_mag;
    logic [30:0] den_mag;
    logic        q_neg;
    logic        p_ok;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/btpc_front.sv
// Front pipeline: temperature path, pressure divisor and numerator setup.
module btpc_front import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [19:0] raw_t,
  input  logic [19:0] raw_p,
  input  cal_t        cal,
  input  logic        adv,
  output logic        push,
  output item_t       item
);

  logic [FRONT_STAGES-1:0] vld_r, vld_nxt;

  logic signed [17:0] s1_a_r, s1_a_nxt, s1_b_r, s1_b_nxt;
  logic        [20:0] s1_pnum_r, s1_pnum_nxt;
  logic signed [31:0] s2_ta_r, s2_ta_nxt, s2_bb_r, s2_bb_nxt;
  logic        [20:0] s2_pnum_r;
  logic signed [20:0] s3_tv1_r, s3_tv1_nxt;
  logic signed [31:0] s3_tb_r, s3_tb_nxt;
  logic        [20:0] s3_pnum_r;
  logic signed [31:0] s4_tfine_r, s4_tfine_nxt;
  logic        [20:0] s4_pnum_r;
  logic signed [31:0] s5_tc5;
  logic signed [22:0] s5_v1_r, s5_v1_nxt;
  logic        [26:0] s5_tcent_r, s5_tcent_nxt;
  logic        [31:0] s5_tfine_r;
  logic        [20:0] s5_pnum_r;
  logic signed [45:0] s6_vv_r, s6_vv_nxt;
  logic signed [38:0] s6_v1p5_r, s6_v1p5_nxt, s6_v1p2_r, s6_v1p2_nxt;
  logic        [31:0] s6_tfine_r;
  logic        [26:0] s6_tcent_r;
  logic        [20:0] s6_pnum_r;
  logic signed [61:0] s7_vvp6_r, s7_vvp6_nxt, s7_vvp3_r, s7_vvp3_nxt;
  logic signed [38:0] s7_v1p5_r, s7_v1p2_r;
  logic        [31:0] s7_tfine_r;
  logic        [26:0] s7_tcent_r;
  logic        [20:0] s7_pnum_r;
  logic signed [61:0] s8_v2_r, s8_v2_nxt;
  logic signed [54:0] s8_x_r, s8_x_nxt;
  logic        [31:0] s8_tfine_r;
  logic        [26:0] s8_tcent_r;
  logic        [20:0] s8_pnum_r;
  logic signed [71:0] s9_dp_full;
  logic signed [30:0] s9_d_r, s9_d_nxt;
  logic signed [61:0] s9_num0_r, s9_num0_nxt;
  logic        [31:0] s9_tfine_r;
  logic        [26:0] s9_tcent_r;
  logic signed [63:0] s10_n_r, s10_n_nxt;
  logic        [30:0] s10_den_r, s10_den_nxt;
  logic               s10_dneg_r, s10_pok_r, s10_pok_nxt;
  logic        [31:0] s10_tfine_r;
  logic        [26:0] s10_tcent_r;
  item_t              s11_r, s11_nxt;

  assign vld_nxt = {vld_r[FRONT_STAGES-2:0], take};

  // Temperature path, 32-bit wrapping words.
  assign s1_a_nxt    = 18'(raw_t[19:3]) - 18'({cal.t1, 1'b0});
  assign s1_b_nxt    = 18'(raw_t[19:4]) - 18'(cal.t1);
  assign s1_pnum_nxt = P_BASE - 21'(raw_p);
  assign s2_ta_nxt   = 32'(s1_a_r * $signed(cal.t2));
  assign s2_bb_nxt   = 32'(s1_b_r * s1_b_r);
  assign s3_tv1_nxt  = s2_ta_r[31:11];
  assign s3_tb_nxt   = 32'($signed(s2_bb_r[31:12]) * $signed(cal.t3));
  assign s4_tfine_nxt = 32'(s3_tv1_r) + 32'($signed(s3_tb_r[31:14]));
  assign s5_tc5       = (s4_tfine_r <<< 2) + s4_tfine_r + T_ROUND;
  assign s5_tcent_nxt = {{3{s5_tc5[31]}}, s5_tc5[31:8]};
  assign s5_v1_nxt    = 23'(s4_tfine_r - T_FINE_OFS);

  // Pressure setup: products are exact at these widths.
  assign s6_vv_nxt   = s5_v1_r * s5_v1_r;
  assign s6_v1p5_nxt = s5_v1_r * $signed(cal.p5);
  assign s6_v1p2_nxt = s5_v1_r * $signed(cal.p2);
  assign s7_vvp6_nxt = s6_vv_r * $signed(cal.p6);
  assign s7_vvp3_nxt = s6_vv_r * $signed(cal.p3);
  assign s8_v2_nxt   = s7_vvp6_r + (62'(s7_v1p5_r) <<< 17)
                     + (62'($signed(cal.p4)) <<< 35);
  assign s8_x_nxt    = 55'($signed(s7_vvp3_r[61:8])) + (55'(s7_v1p2_r) <<< 12) + P_BIAS;
  // Divisor is the wrapped 64-bit product shifted right by 33.
  assign s9_dp_full  = s8_x_r * $signed({1'b0, cal.p1});
  assign s9_d_nxt    = s9_dp_full[63:33];
  assign s9_num0_nxt = 62'({s8_pnum_r, 31'd0}) - s8_v2_r;
  assign s10_n_nxt   = 64'(s9_num0_r * NUM_SCALE);
  assign s10_den_nxt = s9_d_r[30] ? 31'(-s9_d_r) : 31'(s9_d_r);
  assign s10_pok_nxt = (s9_d_r != 31'sd0);

  always_comb begin
    s11_nxt         = '0;
    s11_nxt.tfine   = s10_tfine_r;
    s11_nxt.tcent   = s10_tcent_r;
    s11_nxt.num_mag = s10_n_r[63] ? 64'(-s10_n_r) : 64'(s10_n_r);
    s11_nxt.den_mag = s10_den_r;
    s11_nxt.q_neg   = s10_n_r[63] ^ s10_dneg_r;
    s11_nxt.p_ok    = s10_pok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r      <= s1_a_nxt;
      s1_b_r      <= s1_b_nxt;
      s1_pnum_r   <= s1_pnum_nxt;
      s2_ta_r     <= s2_ta_nxt;
      s2_bb_r     <= s2_bb_nxt;
      s2_pnum_r   <= s1_pnum_r;
      s3_tv1_r    <= s3_tv1_nxt;
      s3_tb_r     <= s3_tb_nxt;
      s3_pnum_r   <= s2_pnum_r;
      s4_tfine_r  <= s4_tfine_nxt;
      s4_pnum_r   <= s3_pnum_r;
      s5_v1_r     <= s5_v1_nxt;
      s5_tcent_r  <= s5_tcent_nxt;
      s5_tfine_r  <= s4_tfine_r;
      s5_pnum_r   <= s4_pnum_r;
      s6_vv_r     <= s6_vv_nxt;
      s6_v1p5_r   <= s6_v1p5_nxt;
      s6_v1p2_r   <= s6_v1p2_nxt;
      s6_tfine_r  <= s5_tfine_r;
      s6_tcent_r  <= s5_tcent_r;
      s6_pnum_r   <= s5_pnum_r;
      s7_vvp6_r   <= s7_vvp6_nxt;
      s7_vvp3_r   <= s7_vvp3_nxt;
      s7_v1p5_r   <= s6_v1p5_r;
      s7_v1p2_r   <= s6_v1p2_r;
      s7_tfine_r  <= s6_tfine_r;
      s7_tcent_r  <= s6_tcent_r;
      s7_pnum_r   <= s6_pnum_r;
      s8_v2_r     <= s8_v2_nxt;
      s8_x_r      <= s8_x_nxt;
      s8_tfine_r  <= s7_tfine_r;
      s8_tcent_r  <= s7_tcent_r;
      s8_pnum_r   <= s7_pnum_r;
      s9_d_r      <= s9_d_nxt;
      s9_num0_r   <= s9_num0_nxt;
      s9_tfine_r  <= s8_tfine_r;
      s9_tcent_r  <= s8_tcent_r;
      s10_n_r     <= s10_n_nxt;
      s10_den_r   <= s10_den_nxt;
      s10_dneg_r  <= s9_d_r[30];
      s10_pok_r   <= s10_pok_nxt;
      s10_tfine_r <= s9_tfine_r;
      s10_tcent_r <= s9_tcent_r;
      s11_r       <= s11_nxt;
    end
  end

  assign push = adv & vld_r[FRONT_STAGES-1];
  assign item = s11_r;

endmodule

>>> rtl/btpc_fifo.sv
// Short item queue between the front pipeline and the divider.
module btpc_fifo import btpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   din,
  input  logic    pop,
  output item_t   dout,
  output q_stat_t stat
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  item_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign wptr_nxt = push ? PW'(wptr_r + 1'b1) : wptr_r;
  assign rptr_nxt = pop  ? PW'(rptr_r + 1'b1) : rptr_r;
  assign cnt_nxt  = CW'(cnt_r + CW'(push) - CW'(pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  assign dout       = mem_r[rptr_r];
  assign stat.full  = (cnt_r == CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

>>> rtl/btpc_back.sv
// Back pipeline: bit-per-stage divider and pressure correction terms.
module btpc_back import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_vld,
  input  item_t       head,
  input  cal_t        cal,
  output logic        pop,
  output logic        res_vld,
  output logic [31:0] res_tfine,
  output logic [26:0] res_tcent,
  output logic [31:0] res_press,
  output logic        res_pok
);

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] dq;
    logic [30:0] den;
    logic        q_neg;
    logic        p_ok;
    logic [31:0] tfine;
    logic [26:0] tcent;
  } dstg_t;

  dstg_t st_in [DIV_STAGES];
  dstg_t st_r  [DIV_STAGES];
  logic  st_vld_r [DIV_STAGES];
  logic  st_vin [DIV_STAGES];

  assign pop = head_vld;

  always_comb begin
    st_in[0]       = '0;
    st_in[0].dq    = head.num_mag;
    st_in[0].den   = head.den_mag;
    st_in[0].q_neg = head.q_neg;
    st_in[0].p_ok  = head.p_ok;
    st_in[0].tfine = head.tfine;
    st_in[0].tcent = head.tcent;
  end
  assign st_vin[0] = head_vld;

  // One quotient bit per stage, restoring form.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    dstg_t       st_nxt;
    logic [31:0] trial;
    logic        ge;

    if (k > 0) begin : g_link
      assign st_in[k]  = st_r[k-1];
      assign st_vin[k] = st_vld_r[k-1];
    end

    always_comb begin
      trial      = {st_in[k].rem, st_in[k].dq[63]};
      ge         = (trial >= {1'b0, st_in[k].den});
      st_nxt     = st_in[k];
      st_nxt.rem = ge ? 31'(trial - {1'b0, st_in[k].den}) : trial[30:0];
      st_nxt.dq  = {st_in[k].dq[62:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k] <= 1'b0;
      end else begin
        st_vld_r[k] <= st_vin[k];
      end
    end

    always_ff @(posedge clk) begin
      st_r[k] <= st_nxt;
    end
  end

  dstg_t              tail;
  logic         [4:0] b_vld_r, b_vld_nxt;
  logic signed [63:0] b0_p_r, b0_p_nxt;
  logic signed [63:0] b1_p_r, b1_m9_r, b1_m9_nxt, b1_m8;
  logic signed [50:0] b1_q13_r;
  logic signed [44:0] b1_w2_r;
  logic        [63:0] b2_y;
  logic        [63:0] b2_ll_r, b2_ll_nxt;
  logic        [31:0] b2_hl_r, b2_hl_nxt, b2_lh_r, b2_lh_nxt;
  logic signed [63:0] b2_p_r, b3_p_r;
  logic signed [44:0] b2_w2_r, b3_w2_r;
  logic        [63:0] b3_prod;
  logic signed [38:0] b3_w1_r;
  logic signed [63:0] b4_sum_r, b4_sum_nxt;
  logic signed [63:0] b5_p;
  logic        [31:0] b5_press;
  logic        [31:0] tf_r [5];
  logic        [26:0] tc_r [5];
  logic               ok_r [5];
  logic               out_vld_r;
  logic        [31:0] out_tfine_r, out_press_r;
  logic        [26:0] out_tcent_r;
  logic               out_pok_r;

  assign tail      = st_r[DIV_STAGES-1];
  assign b_vld_nxt = {b_vld_r[3:0], st_vld_r[DIV_STAGES-1]};

  // Apply the quotient sign.
  assign b0_p_nxt  = tail.q_neg ? $signed(64'(-tail.dq)) : $signed(tail.dq);
  // p9*q and p8*p, low 64 bits.
  assign b1_m9_nxt = 64'($signed(b0_p_r[63:13]) * $signed(cal.p9));
  assign b1_m8     = 64'(b0_p_r * $signed(cal.p8));
  // Low 64 bits of (p9*q)*q from 32-bit partial products.
  assign b2_y      = 64'(b1_q13_r);
  assign b2_ll_nxt = b1_m9_r[31:0] * b2_y[31:0];
  assign b2_hl_nxt = 32'(b1_m9_r[63:32] * b2_y[31:0]);
  assign b2_lh_nxt = 32'(b1_m9_r[31:0] * b2_y[63:32]);
  assign b3_prod   = b2_ll_r + {32'(b2_hl_r + b2_lh_r), 32'd0};
  assign b4_sum_nxt = b3_p_r + 64'(b3_w1_r) + 64'(b3_w2_r);
  assign b5_p       = 64'($signed(b4_sum_r[63:8])) + (64'($signed(cal.p7)) <<< 4);

  always_comb begin
    priority if (!ok_r[4] || b5_p[63]) begin
      b5_press = 32'd0;
    end else if (b5_p[63:32] != 32'd0) begin
      b5_press = 32'hFFFF_FFFF;
    end else begin
      b5_press = b5_p[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= b_vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    b0_p_r   <= b0_p_nxt;
    b1_p_r   <= b0_p_r;
    b1_m9_r  <= b1_m9_nxt;
    b1_q13_r <= b0_p_r[63:13];
    b1_w2_r  <= b1_m8[63:19];
    b2_ll_r  <= b2_ll_nxt;
    b2_hl_r  <= b2_hl_nxt;
    b2_lh_r  <= b2_lh_nxt;
    b2_p_r   <= b1_p_r;
    b2_w2_r  <= b1_w2_r;
    b3_p_r   <= b2_p_r;
    b3_w2_r  <= b2_w2_r;
    b3_w1_r  <= b3_prod[63:25];
    b4_sum_r <= b4_sum_nxt;
    tf_r[0]  <= tail.tfine;
    tc_r[0]  <= tail.tcent;
    ok_r[0]  <= tail.p_ok;
    for (int i = 1; i < 5; i++) begin
      tf_r[i] <= tf_r[i-1];
      tc_r[i] <= tc_r[i-1];
      ok_r[i] <= ok_r[i-1];
    end
    out_tfine_r <= tf_r[4];
    out_tcent_r <= tc_r[4];
    out_press_r <= b5_press;
    out_pok_r   <= ok_r[4];
  end

  assign res_vld   = out_vld_r;
  assign res_tfine = out_tfine_r;
  assign res_tcent = out_tcent_r;
  assign res_press = out_press_r;
  assign res_pok   = out_pok_r;

endmodule

>>> rtl/baro_temp_pressure_compensation.sv
// Top level: calibration registers, front pipeline, item queue and back pipeline.
// Usage:
//  - Load the four 48-bit calibration registers over the APB-style port
//    (byte addresses 0, 8, 16, 24; data in pwdata[47:0]). Write them only
//    while no reading pair is in flight. Reads return the stored words.
//  - Present a raw temperature/pressure pair with start high; the pair is
//    taken at the edge where start is high and busy is low.
//  - One result leaves per pair: out_valid is high for exactly one cycle
//    with fine temperature, centidegrees, pressure (Pa, Q24.8) and the
//    pressure valid flag. A zero divisor gives pressure 0 with the flag low.
// Timing:
//  - From the accepting edge to out_valid a pair passes 11 front stages,
//    one queue slot, 64 divider stages (one quotient bit each) and 6
//    correction/clamp stages.
//  - Throughput is one pair per cycle; every stage is a register and the
//    divider is fully pipelined.
//  - The back pipeline pops the queue head whenever there is one, so the queue
//    never fills, busy stays low, nothing stalls; results cannot be held off.
// Reset (synchronous, rst_n low) clears all calibration words to zero and
// drops every item in flight.
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  output logic        out_valid,
  output logic [31:0] out_fine_temperature,
  output logic [26:0] out_temperature_centi,
  output logic [31:0] out_pressure_q24_8,
  output logic        out_pressure_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0] temp_coeffs_r, temp_coeffs_nxt;
  logic [47:0] press_a_r, press_a_nxt;
  logic [47:0] press_b_r, press_b_nxt;
  logic [47:0] press_c_r, press_c_nxt;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  cal_t        cal;
  logic        take;
  logic        f_push;
  item_t       f_item;
  item_t       q_head;
  q_stat_t     q_stat;
  logic        b_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:3];

  // Update the addressed calibration word; hold the others.
  always_comb begin
    temp_coeffs_nxt = temp_coeffs_r;
    press_a_nxt     = press_a_r;
    press_b_nxt     = press_b_r;
    press_c_nxt     = press_c_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TEMP:    temp_coeffs_nxt = pwdata[47:0];
        REG_PRESS_A: press_a_nxt     = pwdata[47:0];
        REG_PRESS_B: press_b_nxt     = pwdata[47:0];
        REG_PRESS_C: press_c_nxt     = pwdata[47:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_c_r     <= '0;
    end else begin
      temp_coeffs_r <= temp_coeffs_nxt;
      press_a_r     <= press_a_nxt;
      press_b_r     <= press_b_nxt;
      press_c_r     <= press_c_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TEMP:    prdata = {16'd0, temp_coeffs_r};
      REG_PRESS_A: prdata = {16'd0, press_a_r};
      REG_PRESS_B: prdata = {16'd0, press_b_r};
      REG_PRESS_C: prdata = {16'd0, press_c_r};
    endcase
  end

  // Split the register words into coefficients.
  assign cal.t1 = temp_coeffs_r[15:0];
  assign cal.t2 = temp_coeffs_r[31:16];
  assign cal.t3 = temp_coeffs_r[47:32];
  assign cal.p1 = press_a_r[15:0];
  assign cal.p2 = press_a_r[31:16];
  assign cal.p3 = press_a_r[47:32];
  assign cal.p4 = press_b_r[15:0];
  assign cal.p5 = press_b_r[31:16];
  assign cal.p6 = press_b_r[47:32];
  assign cal.p7 = press_c_r[15:0];
  assign cal.p8 = press_c_r[31:16];
  assign cal.p9 = press_c_r[47:32];

  // Hold the front and refuse new beats while the queue is full.
  assign busy = q_stat.full;
  assign take = start & ~busy;

  btpc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .raw_t (in_raw_temperature),
    .raw_p (in_raw_pressure),
    .cal   (cal),
    .adv   (~q_stat.full),
    .push  (f_push),
    .item  (f_item)
  );

  btpc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .pop   (b_pop),
    .dout  (q_head),
    .stat  (q_stat)
  );

  btpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (~q_stat.empty),
    .head      (q_head),
    .cal       (cal),
    .pop       (b_pop),
    .res_vld   (out_valid),
    .res_tfine (out_fine_temperature),
    .res_tcent (out_temperature_centi),
    .res_press (out_pressure_q24_8),
    .res_pok   (out_pressure_valid)
  );

  // Never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !f_push)
    else $error("item pushed into a full queue");

  // Every accepted beat comes out after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##PIPE_LATENCY out_valid)
    else $error("result missing at expected latency");

  // A rejected divisor forces the pressure to zero.
  a_bad_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pressure_valid) |-> (out_pressure_q24_8 == 32'd0))
    else $error("pressure nonzero with divisor flag low");

endmodule

>>> tb/tb.sv
// Testbench for the barometric temperature and pressure compensation block.
`timescale 1ns / 1ps

module tb import btpc_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [19:0] in_raw_temperature;
  logic [19:0] in_raw_pressure;
  logic        out_valid;
  logic [31:0] out_fine_temperature;
  logic [26:0] out_temperature_centi;
  logic [31:0] out_pressure_q24_8;
  logic        out_pressure_valid;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // One expected compensated reading.
  typedef struct packed {
    logic [31:0] tfine;
    logic [26:0] tcent;
    logic [31:0] press;
    logic        pvalid;
  } reading_t;

  reading_t    expected_readings[$];
  logic [47:0] cal_words[4];
  int          error_count;
  int          cycle_count;

  localparam int CYCLE_LIMIT = 400000;

  baro_temp_pressure_compensation i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_raw_temperature    (in_raw_temperature),
    .in_raw_pressure       (in_raw_pressure),
    .out_valid             (out_valid),
    .out_fine_temperature  (out_fine_temperature),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_q24_8    (out_pressure_q24_8),
    .out_pressure_valid    (out_pressure_valid),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run; the limit covers the slowest legal run several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Sign-extend one 16-bit calibration field.
  function automatic logic signed [63:0] cal_field(input logic [47:0] w, input int lo);
    logic [15:0] f;
    f = w[lo +: 16];
    return {{48{f[15]}}, f};
  endfunction

  // Predict the compensated reading from the raw pair and the held calibration.
  function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
    logic signed [31:0] t1, t2, t3, a, b, tv1, tv2, tfine, bb, tc;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, q, w1, w2, num;
    logic [63:0]        an, ad, uq;
    reading_t           r;
    t1 = {16'd0, cal_words[0][15:0]};
    t2 = 32'(cal_field(cal_words[0], 16));
    t3 = 32'(cal_field(cal_words[0], 32));
    a = 32'({12'd0, raw_t >> 3}) - (t1 <<< 1);
    tv1 = (a * t2) >>> 11;
    b = 32'({12'd0, raw_t >> 4}) - t1;
    bb = (b * b) >>> 12;
    tv2 = (bb * t3) >>> 14;
    tfine = tv1 + tv2;
    tc = (tfine * 32'sd5 + 32'sd128) >>> 8;
    p1 = {48'd0, cal_words[1][15:0]};
    p2 = cal_field(cal_words[1], 16);
    p3 = cal_field(cal_words[1], 32);
    p4 = cal_field(cal_words[2], 0);
    p5 = cal_field(cal_words[2], 16);
    p6 = cal_field(cal_words[2], 32);
    p7 = cal_field(cal_words[3], 0);
    p8 = cal_field(cal_words[3], 16);
    p9 = cal_field(cal_words[3], 32);
    v1 = 64'(tfine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    r.tfine  = tfine;
    r.tcent  = tc[26:0];
    r.press  = '0;
    r.pvalid = 1'b0;
    if (v1 != 0) begin
      p = 64'sd1048576 - 64'($unsigned(raw_p));
      num = ((p <<< 31) - v2) * 64'sd3125;
      // Truncate toward zero on magnitudes; the most negative case wraps.
      an = num[63] ? -num : num;
      ad = v1[63] ? -v1 : v1;
      uq = an / ad;
      p = (num[63] != v1[63]) ? -uq : uq;
      q = p >>> 13;
      w1 = (p9 * q * q) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      if (p[63]) r.press = '0;
      else if (p[63:32] != 0) r.press = 32'hFFFFFFFF;
      else r.press = p[31:0];
      r.pvalid = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    reading_t e;
    if (rst_n && out_valid) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result beat", 32'd1, 32'd0);
      end else begin
        e = expected_readings.pop_front();
        if (out_fine_temperature !== e.tfine)
          report_mismatch("fine_temperature", out_fine_temperature, e.tfine);
        if (out_temperature_centi !== e.tcent)
          report_mismatch("temperature_centi", 32'(out_temperature_centi), 32'(e.tcent));
        if (out_pressure_q24_8 !== e.press)
          report_mismatch("pressure_q24_8", out_pressure_q24_8, e.press);
        if (out_pressure_valid !== e.pvalid)
          report_mismatch("pressure_valid", 32'(out_pressure_valid), 32'(e.pvalid));
      end
    end
  end

  // Sender burst state: random burst length, random gap before it.
  int burst_left;

  // Send one reading pair; honor the burst/gap pattern before raising start.
  task automatic send_pair(input logic [19:0] raw_t, input logic [19:0] raw_p);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start              <= 1'b1;
    in_raw_temperature <= raw_t;
    in_raw_pressure    <= raw_p;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_readings.push_back(compensate(raw_t, raw_p));
  endtask

  // Hold off until every expected beat has arrived, then let the pipe drain.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // Write one calibration register through a setup and an access cycle.
  task automatic write_cal(input logic [1:0] idx, input logic [47:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cal_words[idx] = value;
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [47:0] pa,
                          input logic [47:0] pb, input logic [47:0] pc);
    drain();
    write_cal(REG_TEMP, tc);
    write_cal(REG_PRESS_A, pa);
    write_cal(REG_PRESS_B, pb);
    write_cal(REG_PRESS_C, pc);
  endtask

  // Typical factory calibration words, so the divisor is nonzero and values are sane.
  task automatic load_typical;
    load_cal({16'hFC18, 16'h6A00, 16'h6E00}, {16'hD0D0, 16'hD6D0, 16'h8F00},
             {16'hFFF9, 16'h008C, 16'h2000}, {16'h1770, 16'hC5F8, 16'h000F});
  endtask

  // Zero calibration after reset: divisor is zero, pressure flagged invalid.
  task automatic test_zero_divisor;
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'h80000, 20'h12345);
  endtask

  // Field extremes and clamping with typical and extreme coefficients.
  task automatic test_directed;
    load_typical();
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'd519888, 20'd415148);
    send_pair(20'hFFFFF, 20'd0);
    send_pair(20'd0, 20'hFFFFF);
    // Tiny P1 and large P7 to P9 exercise the pressure clamps above 32 bits and below zero.
    load_cal({16'hFC18, 16'h6A00, 16'h6E00}, {16'hD0D0, 16'hD6D0, 16'h0001},
             {16'hFFF9, 16'h008C, 16'h2000}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_pair(20'd519888, 20'd0);
    send_pair(20'd519888, 20'hFFFFF);
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
             {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'h55555, 20'hAAAAA);
    load_cal(48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF);
    send_pair(20'd0, 20'hFFFFF);
    send_pair(20'hAAAAA, 20'h55555);
  endtask

  // Random readings under several calibration sets; mostly realistic words.
  task automatic test_random;
    for (int set = 0; set < 8; set++) begin
      if (set % 3 == 2)
        load_cal(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                 48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
      else begin
        load_typical();
        cal_words[0][15:0] = 16'($urandom_range(20000, 32000));
        write_cal(REG_TEMP, cal_words[0]);
      end
      for (int n = 0; n < 180; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_pair(20'($urandom()), 20'($urandom()));
        else
          send_pair(20'($urandom_range(400000, 600000)), 20'($urandom_range(200000, 600000)));
      end
    end
  endtask

  initial begin
    burst_left         = 0;
    for (int i = 0; i < 4; i++) cal_words[i] = '0;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure    = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_divisor();
    test_directed();
    test_random();
    drain();
    if (error_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
